// ===== rtl/core/weighted_adjacency_matrix_store_macros.svh =====
// Assertion macros shared by the checker of the road matrix store.
`ifndef WEIGHTED_ADJACENCY_MATRIX_STORE_MACROS_SVH
`define WEIGHTED_ADJACENCY_MATRIX_STORE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent; skipped in reset.
`define WAMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent; skipped in reset.
`define WAMS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle check that also covers the reset cycles.
`define WAMS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("reset check failed");

`endif

// ===== rtl/core/wams_pkg.sv =====
// Types and constants of the road matrix store.
package wams_pkg;

   localparam int CITY_W       = 5;
   localparam int LEN_W        = 16;
   localparam int TOTAL_W      = 9;
   localparam int MODE_W       = 2;
   localparam int CSR_W        = 6;
   localparam int RESULT_LIMIT = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 9'd511;

   localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LIST     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_PRESENT  = 2'd1,
      STAT_BAD      = 2'd2,
      STAT_ISOLATED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_MIRROR,
      S_SCAN,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic lookup;
      logic mirror;
      logic scan;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic req_bad;
      logic req_list;
      logic clear_done;
      logic insert_free;
      logic scan_last;
   } stat_type;

endpackage

// ===== rtl/core/wams_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wams_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 1024,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/wams_ctrl.sv =====
// Sequencer of the road matrix store: clearing, lookup, insert and row scan.
module wams_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  wams_pkg::stat_type stat,
   output wams_pkg::cmd_type  cmd
);
   import wams_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start && !stat.req_bad) begin
               state_in = stat.req_list ? S_SCAN : S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = stat.insert_free ? S_MIRROR : S_IDLE;
         end
         S_MIRROR: begin
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (stat.scan_last) state_in = S_FLUSH;
         end
         S_FLUSH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_CLEAR:  cmd.clear_step = 1'b1;
         S_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         S_LOOKUP: cmd.lookup = 1'b1;
         S_MIRROR: cmd.mirror = 1'b1;
         S_SCAN:   cmd.scan   = 1'b1;
         S_FLUSH:  cmd.flush  = 1'b1;
         default:  busy       = 1'b1;
      endcase
   end

endmodule

// ===== rtl/core/wams_datapath.sv =====
// Datapath of the road matrix store: request checks, matrix RAM, counters, result register.
module wams_datapath #(
   parameter int MAX_CITIES  = 32,
   parameter int LENGTH_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wams_pkg::cmd_type             cmd,
   output wams_pkg::stat_type            stat,
   input  logic [wams_pkg::MODE_W-1:0]   req_mode,
   input  logic [wams_pkg::CITY_W-1:0]   req_city_a,
   input  logic [wams_pkg::CITY_W-1:0]   req_city_b,
   input  logic [wams_pkg::LEN_W-1:0]    req_road_length,
   input  logic                          csr_valid,
   input  logic [wams_pkg::CSR_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [wams_pkg::CITY_W-1:0]   rsp_from_city,
   output logic [wams_pkg::CITY_W-1:0]   rsp_to_city,
   output logic [wams_pkg::LEN_W-1:0]    rsp_found_length,
   output logic [wams_pkg::TOTAL_W-1:0]  rsp_total_roads,
   output logic                          rsp_last
);
   import wams_pkg::*;

   localparam int CITY_BITS  = $clog2(MAX_CITIES);
   localparam int DEPTH      = MAX_CITIES * MAX_CITIES;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(MAX_CITIES + 1);
   localparam int LEN_CHK    = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
   localparam int FOUND_BITS = $clog2(RESULT_LIMIT + 1);
   localparam int CITIES_RST = (MAX_CITIES < 32) ? MAX_CITIES : 32;

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [CITY_BITS-1:0] row,
                                                      input logic [CITY_BITS-1:0] col);
      return ADDR_BITS'(row) * ADDR_BITS'(MAX_CITIES) + ADDR_BITS'(col);
   endfunction

   // request held for the multi-cycle operations
   logic [MODE_W-1:0]      mode_ff;
   logic [CITY_W-1:0]      a_ff;
   logic [CITY_W-1:0]      b_ff;
   logic [LEN_W-1:0]       len_ff;

   logic [CNT_BITS-1:0]    cities_ff;
   logic [CNT_BITS-1:0]    cities_in;
   logic [TOTAL_W-1:0]     total_ff;
   logic [TOTAL_W-1:0]     total_in;
   logic [ADDR_BITS-1:0]   clr_addr_ff;

   logic [CITY_BITS-1:0]   scan_col_ff;
   logic [CITY_BITS-1:0]   scan_col_in;
   logic [FOUND_BITS-1:0]  found_ff;
   logic                   pend_valid_ff;
   logic [CITY_BITS-1:0]   pend_col_ff;
   logic [LENGTH_BITS-1:0] pend_len_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [CITY_W-1:0]      rsp_from_ff;
   logic [CITY_W-1:0]      rsp_to_ff;
   logic [LEN_W-1:0]       rsp_len_ff;
   logic [TOTAL_W-1:0]     rsp_total_ff;
   logic                   rsp_last_ff;

   logic                   p_a_ok;
   logic                   p_b_ok;
   logic                   p_same;
   logic                   p_len_fits;
   logic                   p_bad;
   logic                   p_list;
   logic                   hit;

   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [LENGTH_BITS-1:0] wr_data;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [LENGTH_BITS-1:0] rd_data;

   logic                   emit;
   status_type             e_status;
   logic [CITY_W-1:0]      e_from;
   logic [CITY_W-1:0]      e_to;
   logic [LEN_W-1:0]       e_len;
   logic                   e_last;

   // checks on the request as it stands on the ports
   always_comb begin
      p_a_ok     = int'(req_city_a) < int'(cities_ff);
      p_b_ok     = int'(req_city_b) < int'(cities_ff);
      p_same     = req_city_a == req_city_b;
      p_len_fits = (32'(req_road_length) >> LEN_CHK) == 32'd0;
      p_list     = req_mode == MODE_LIST;
      unique case (req_mode)
         MODE_INSERT: p_bad = !p_a_ok || !p_b_ok || p_same ||
                              (req_road_length == '0) || !p_len_fits;
         MODE_QUERY:  p_bad = !p_a_ok || !p_b_ok || p_same;
         MODE_LIST:   p_bad = !p_a_ok;
         default:     p_bad = 1'b1;
      endcase
   end

   assign hit = (rd_data != '0) && (found_ff < FOUND_BITS'(RESULT_LIMIT));

   always_comb begin
      stat.req_bad     = p_bad;
      stat.req_list    = p_list;
      stat.clear_done  = clr_addr_ff == ADDR_BITS'(DEPTH - 1);
      stat.insert_free = (mode_ff == MODE_INSERT) && (rd_data == '0);
      stat.scan_last   = (int'(scan_col_ff) + 1) == int'(cities_ff);
   end

   // hold the column on the final one so the read address stays in range
   assign scan_col_in = stat.scan_last ? scan_col_ff : scan_col_ff + 1'b1;

   always_comb begin
      if (cmd.scan) begin
         rd_addr = cell_addr(CITY_BITS'(a_ff), scan_col_in);
      end else begin
         rd_addr = cell_addr(CITY_BITS'(req_city_a),
                             p_list ? '0 : CITY_BITS'(req_city_b));
      end
   end

   always_comb begin
      wr_en   = cmd.clear_step || (cmd.lookup && stat.insert_free) || cmd.mirror;
      wr_data = cmd.clear_step ? '0 : LENGTH_BITS'(len_ff);
      if (cmd.clear_step) begin
         wr_addr = clr_addr_ff;
      end else if (cmd.mirror) begin
         wr_addr = cell_addr(CITY_BITS'(b_ff), CITY_BITS'(a_ff));
      end else begin
         wr_addr = cell_addr(CITY_BITS'(a_ff), CITY_BITS'(b_ff));
      end
   end

   wams_ram #(
      .WIDTH (LENGTH_BITS),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (int'(csr_wdata) == 0) begin
         cities_in = CNT_BITS'(1);
      end else if (int'(csr_wdata) > MAX_CITIES) begin
         cities_in = CNT_BITS'(MAX_CITIES);
      end else begin
         cities_in = CNT_BITS'(csr_wdata);
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.lookup && stat.insert_free && (total_ff != TOTAL_MAX)) begin
         total_in = total_ff + 1'b1;
      end
   end

   // pick the result to register this cycle, if any
   always_comb begin
      emit     = 1'b0;
      e_status = STAT_OK;
      e_from   = a_ff;
      e_to     = b_ff;
      e_len    = '0;
      e_last   = 1'b1;
      if (cmd.accept && p_bad) begin
         emit     = 1'b1;
         e_status = STAT_BAD;
         e_from   = req_city_a;
         e_to     = p_list ? '0 : req_city_b;
      end else if (cmd.lookup && !stat.insert_free) begin
         emit     = 1'b1;
         e_status = (mode_ff == MODE_INSERT) ? STAT_PRESENT : STAT_OK;
         e_len    = LEN_W'(rd_data);
      end else if (cmd.mirror) begin
         emit  = 1'b1;
         e_len = len_ff;
      end else if (cmd.scan && hit && pend_valid_ff) begin
         // a newer neighbor exists, so the held one is not the final result
         emit   = 1'b1;
         e_to   = CITY_W'(pend_col_ff);
         e_len  = LEN_W'(pend_len_ff);
         e_last = 1'b0;
      end else if (cmd.flush) begin
         emit = 1'b1;
         if (pend_valid_ff) begin
            e_to  = CITY_W'(pend_col_ff);
            e_len = LEN_W'(pend_len_ff);
         end else begin
            e_status = STAT_ISOLATED;
            e_to     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cities_ff     <= CNT_BITS'(CITIES_RST);
         total_ff      <= '0;
         clr_addr_ff   <= '0;
         found_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) cities_ff <= cities_in;
         total_ff     <= total_in;
         rsp_valid_ff <= emit;
         if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (cmd.accept) begin
            found_ff      <= '0;
            pend_valid_ff <= 1'b0;
         end else if (cmd.scan && hit) begin
            found_ff      <= found_ff + 1'b1;
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff     <= req_mode;
         a_ff        <= req_city_a;
         b_ff        <= req_city_b;
         len_ff      <= req_road_length;
         scan_col_ff <= '0;
      end else if (cmd.scan) begin
         scan_col_ff <= scan_col_in;
      end
      if (cmd.scan && hit) begin
         pend_col_ff <= scan_col_ff;
         pend_len_ff <= rd_data;
      end
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_from_ff   <= e_from;
         rsp_to_ff     <= e_to;
         rsp_len_ff    <= e_len;
         rsp_total_ff  <= total_ff;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_from_city    = rsp_from_ff;
   assign rsp_to_city      = rsp_to_ff;
   assign rsp_found_length = rsp_len_ff;
   assign rsp_total_roads  = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== rtl/core/weighted_adjacency_matrix_store.sv =====
// Top level of the weighted road matrix store.
//
// Requests: drive req_* and raise start; a request transfers at a clock edge
// where start is high and busy is low. Modes are insert, query and list.
// Results: each result is shown for one cycle with rsp_valid high; the
// receiver must take it then, it cannot stall the block. rsp_last marks the
// final result of a request.
// Configuration: csr_wdata (cities in use, saturated to 1..MAX_CITIES)
// transfers when csr_valid and csr_ready are high; csr_ready is always high.
// Write it only while no request is in flight.
// Timing, counted from the accepting edge: a rejected request gives its
// result in the next cycle and busy never rises. A query holds busy in the
// lookup state, an insert in the lookup and, if the cell was free, then the
// mirrored write; the result shows in the first cycle with busy low. A list
// walks the row one entry per cycle from the matrix RAM read port and is busy
// through the scan and flush states; each neighbor is held until the next one
// is found and shows in the cycle after that, and the final one shows in the
// first cycle with busy low. Reset: synchronous; the matrix is then cleared
// one entry per cycle with busy high. Road count resets to zero, cities in
// use to 32 (or MAX_CITIES if smaller).
module weighted_adjacency_matrix_store #(
   parameter int MAX_CITIES  = 32,
   parameter int LENGTH_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [wams_pkg::MODE_W-1:0]   req_mode,
   input  logic [wams_pkg::CITY_W-1:0]   req_city_a,
   input  logic [wams_pkg::CITY_W-1:0]   req_city_b,
   input  logic [wams_pkg::LEN_W-1:0]    req_road_length,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wams_pkg::CSR_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [wams_pkg::CITY_W-1:0]   rsp_from_city,
   output logic [wams_pkg::CITY_W-1:0]   rsp_to_city,
   output logic [wams_pkg::LEN_W-1:0]    rsp_found_length,
   output logic [wams_pkg::TOTAL_W-1:0]  rsp_total_roads,
   output logic                          rsp_last
);
   import wams_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   wams_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   wams_datapath #(
      .MAX_CITIES  (MAX_CITIES),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_city_a       (req_city_a),
      .req_city_b       (req_city_b),
      .req_road_length  (req_road_length),
      .csr_valid        (csr_valid),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_from_city    (rsp_from_city),
      .rsp_to_city      (rsp_to_city),
      .rsp_found_length (rsp_found_length),
      .rsp_total_roads  (rsp_total_roads),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== rtl/core/wams_checker.sv =====
// Port-level checks of the road matrix store, bound to its top level.
`include "weighted_adjacency_matrix_store_macros.svh"

module wams_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [wams_pkg::MODE_W-1:0] req_mode,
   input logic                        rsp_valid,
   input logic [1:0]                  rsp_status,
   input logic                        rsp_last
);
   import wams_pkg::*;

   // after reset the matrix is being cleared and nothing is reported
   `WAMS_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, busy && !rsp_valid)

   // the reserved mode is rejected with a single final result
   `WAMS_ASSERT_NEXT(a_reserved_rejected, clock, reset, start && !busy && (req_mode == MODE_RESERVED), rsp_valid && (rsp_status == STAT_BAD) && rsp_last)

   // every transfer either keeps the block busy or answers at once
   `WAMS_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid)

   // a non-final list result means the row walk is still running
   `WAMS_ASSERT_SAME(a_partial_busy, clock, reset, rsp_valid && !rsp_last, busy)

endmodule

bind weighted_adjacency_matrix_store wams_checker u_checker (.*);
